// ----- hdl/svpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc_pkg: shared types and constants of the stepper valve controller
// Item and result layouts, operation and register codes, sequencer states and
// the request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package svpc_pkg;

    // Position range of the valve
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Field and datapath widths
    localparam int MS_BITS    = 10;
    localparam int DT_BITS    = 20;
    localparam int ACC_BITS   = 32;
    localparam int IV_BITS    = 20;
    localparam int STEP_BITS  = 17;
    localparam int PROD_BITS  = STEP_BITS + IV_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [MS_BITS-1:0]  US_PER_MS = 10'd1000;
    localparam logic [ACC_BITS-1:0] ACC_SAT   = {ACC_BITS{1'b1}};

    // Register reset values
    localparam logic [POS_BITS-1:0] RST_MAX_STEPS   = 16'd480;
    localparam logic [15:0]         RST_HOMING_XTRA = 16'd50;
    localparam logic [IV_BITS-1:0]  RST_STEP_IV     = 20'd20000;
    localparam logic [IV_BITS-1:0]  RST_EMERG_IV    = 20'd6666;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_HOME       = 2'd2,
        OP_EMERGENCY  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_STEPS    = 3'd0,
        CFG_HOMING_EXTRA = 3'd1,
        CFG_STEP_IV      = 3'd2,
        CFG_EMERG_IV     = 3'd3,
        CFG_INVERT_DIR   = 3'd4,
        CFG_ENABLE_PIN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CLAMP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        t_op                 operation;
        logic [MS_BITS-1:0]  elapsed_ms;
        logic [POS_BITS-1:0] target_position;
    } t_in;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_count;
        logic                 direction_level;
        logic                 enable_level;
        logic [POS_BITS-1:0]  position;
        logic [POS_BITS-1:0]  goal_position;
        logic                 calibrated;
        logic                 homing_active;
        logic                 emergency_active;
        logic                 save_request;
        logic                 command_accepted;
    } t_out;

    typedef struct packed {
        logic                start;
        logic [ACC_BITS-1:0] dividend;
        logic [IV_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] quotient;
        logic [IV_BITS-1:0]  remainder;
    } t_div_rsp;

endpackage

// ----- hdl/stepper_valve_position_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_valve_position_controller: stepper expansion valve sequencer
// Tracks valve position, goal, homing and emergency close, and tells the
// pin driver how many steps to emit per beat and at which pin levels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) takes one beat per
//   tick, set-target, start-homing or emergency-close command. Every input
//   beat yields exactly one result beat on o_out_valid / i_out_ready (o_out).
//   Configuration beats (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   are always taken; write them only while the block is idle. Unknown
//   indexes are dropped.
//   Sequence: a tick that moves the valve runs the shared restoring divider,
//   one quotient bit per cycle over the 32-bit accumulator, and passes
//   through the prepare, divide, clamp and final steps in that order. Every
//   other item goes from the idle step straight to the final step. The
//   final step writes the result register and frees the input.
//   Throughput is one item at a time: o_in_ready is high only while the
//   sequencer is idle.
//   One output register holds the result: a new input beat is taken while a
//   result still waits, but the next result holds in the final step until
//   the receiver frees the register.
//   Reset (synchronous, active low) restores the register defaults, clears
//   position, goal, accumulator and all status, and drops a pending result.
// ----------------------------------------------------------------------------
module stepper_valve_position_controller
    import svpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers
    logic [POS_BITS-1:0] r_max_steps;
    logic [15:0]         r_homing_extra;
    logic [IV_BITS-1:0]  r_step_iv;
    logic [IV_BITS-1:0]  r_emerg_iv;
    logic                r_invert_dir;
    logic                r_enable_pin;

    // Valve state
    t_state               r_state, n_state;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_goal, n_goal;
    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [STEP_BITS-1:0] r_home_rem, n_home_rem;
    logic                 r_homing, n_homing;
    logic                 r_cal, n_cal;
    logic                 r_fast, n_fast;
    logic                 r_drv_en, n_drv_en;
    logic                 r_dir, n_dir;

    // Item in flight
    t_op                  r_op, n_op;
    logic [DT_BITS-1:0]   r_dt, n_dt;
    logic [POS_BITS-1:0]  r_target, n_target;
    logic                 r_move, n_move;
    logic [ACC_BITS-1:0]  r_sum, n_sum;
    logic                 r_clamp, n_clamp;
    logic [STEP_BITS-1:0] r_steps, n_steps;
    logic [PROD_BITS-1:0] r_prod, n_prod;

    // Result register
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    // Shared divider
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    // Working values
    logic                 opening;
    logic [POS_BITS-1:0]  travel;
    logic [IV_BITS-1:0]   iv_raw;
    logic [IV_BITS-1:0]   iv;
    logic [STEP_BITS-1:0] limit;
    logic [ACC_BITS:0]    sum_wide;
    logic [ACC_BITS-1:0]  sum_sat;
    logic                 out_free;
    logic [STEP_BITS-1:0] steps;
    logic [STEP_BITS-1:0] home_left;
    logic [POS_BITS-1:0]  new_pos;
    logic [POS_BITS-1:0]  tgt_lim;
    logic [POS_BITS-1:0]  tgt;
    logic                 save;
    logic                 accepted;

    svpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Motion operands, all taken from settled state
    always_comb begin
        opening  = (r_goal > r_pos);
        travel   = opening ? (r_goal - r_pos) : (r_pos - r_goal);
        iv_raw   = (r_homing || !r_fast) ? r_step_iv : r_emerg_iv;
        iv       = (iv_raw == '0) ? IV_BITS'(1) : iv_raw;
        limit    = r_homing ? r_home_rem : STEP_BITS'(travel);
        sum_wide = {1'b0, r_acc} + (ACC_BITS + 1)'(r_dt);
        sum_sat  = sum_wide[ACC_BITS] ? ACC_SAT : sum_wide[ACC_BITS-1:0];
        out_free = !r_out_valid || i_out_ready;
    end

    // Sequencer: next state, divider request and state updates
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_goal      = r_goal;
        n_acc       = r_acc;
        n_home_rem  = r_home_rem;
        n_homing    = r_homing;
        n_cal       = r_cal;
        n_fast      = r_fast;
        n_drv_en    = r_drv_en;
        n_dir       = r_dir;
        n_op        = r_op;
        n_dt        = r_dt;
        n_target    = r_target;
        n_move      = r_move;
        n_sum       = r_sum;
        n_clamp     = r_clamp;
        n_steps     = r_steps;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        div_req     = '0;
        steps       = '0;
        home_left   = '0;
        new_pos     = r_pos;
        tgt_lim     = '0;
        tgt         = '0;
        save        = 1'b0;
        accepted    = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in.operation;
                    n_dt     = DT_BITS'(i_in.elapsed_ms) * DT_BITS'(US_PER_MS);
                    n_target = i_in.target_position;
                    if (i_in.operation == OP_TICK && (r_homing || r_pos != r_goal)) begin
                        n_move  = 1'b1;
                        n_state = ST_PREP;
                    end else begin
                        n_move  = 1'b0;
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_PREP: begin
                // Add the elapsed time and start the interval division
                div_req.start    = 1'b1;
                div_req.dividend = sum_sat;
                div_req.divisor  = iv;
                n_sum            = sum_sat;
                n_state          = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                // Cap the step count at the distance still needed
                n_clamp = (div_rsp.quotient > ACC_BITS'(limit));
                n_steps = n_clamp ? limit : div_rsp.quotient[STEP_BITS-1:0];
                n_prod  = limit * iv;
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    case (r_op)
                        OP_TICK: begin
                            if (r_move) begin
                                steps = r_steps;
                                n_acc = r_clamp ? (r_sum - r_prod[ACC_BITS-1:0])
                                                : ACC_BITS'(div_rsp.remainder);
                                if (r_homing) begin
                                    if (steps != '0) begin
                                        n_dir = r_invert_dir;
                                    end
                                    home_left  = r_home_rem - steps;
                                    n_home_rem = home_left;
                                    if (home_left == '0) begin
                                        n_pos    = '0;
                                        n_goal   = '0;
                                        n_cal    = 1'b1;
                                        n_homing = 1'b0;
                                        save     = 1'b1;
                                    end
                                end else begin
                                    if (steps != '0) begin
                                        n_dir = opening ^ r_invert_dir;
                                    end
                                    new_pos = opening ? (r_pos + steps[POS_BITS-1:0])
                                                      : (r_pos - steps[POS_BITS-1:0]);
                                    n_pos   = new_pos;
                                    if (new_pos == r_goal) begin
                                        n_fast = 1'b0;
                                        save   = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_SET_TARGET: begin
                            tgt_lim = (r_max_steps < POS_MAX) ? r_max_steps : POS_MAX;
                            tgt     = (r_target > tgt_lim) ? tgt_lim : r_target;
                            if (!r_cal) begin
                                accepted = 1'b0;
                            end else begin
                                n_goal = tgt;
                                if (r_enable_pin) begin
                                    n_drv_en = 1'b1;
                                end
                            end
                        end
                        OP_HOME: begin
                            if (r_enable_pin) begin
                                n_drv_en = 1'b1;
                            end
                            n_home_rem = STEP_BITS'(r_max_steps) + STEP_BITS'(r_homing_extra);
                            n_homing   = 1'b1;
                            n_acc      = '0;
                        end
                        OP_EMERGENCY: begin
                            n_goal = '0;
                            n_fast = 1'b1;
                            if (r_enable_pin) begin
                                n_drv_en = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    n_out.step_count       = steps;
                    n_out.direction_level  = n_dir;
                    n_out.enable_level     = !(r_enable_pin && n_drv_en);
                    n_out.position         = n_pos;
                    n_out.goal_position    = n_goal;
                    n_out.calibrated       = n_cal;
                    n_out.homing_active    = n_homing;
                    n_out.emergency_active = n_fast;
                    n_out.save_request     = save;
                    n_out.command_accepted = accepted;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_goal      <= '0;
            r_acc       <= '0;
            r_home_rem  <= '0;
            r_homing    <= 1'b0;
            r_cal       <= 1'b0;
            r_fast      <= 1'b0;
            r_drv_en    <= 1'b0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_goal      <= n_goal;
            r_acc       <= n_acc;
            r_home_rem  <= n_home_rem;
            r_homing    <= n_homing;
            r_cal       <= n_cal;
            r_fast      <= n_fast;
            r_drv_en    <= n_drv_en;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dt     <= n_dt;
        r_target <= n_target;
        r_move   <= n_move;
        r_sum    <= n_sum;
        r_clamp  <= n_clamp;
        r_steps  <= n_steps;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps    <= RST_MAX_STEPS;
            r_homing_extra <= RST_HOMING_XTRA;
            r_step_iv      <= RST_STEP_IV;
            r_emerg_iv     <= RST_EMERG_IV;
            r_invert_dir   <= 1'b0;
            r_enable_pin   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_STEPS:    r_max_steps    <= i_cfg_data[POS_BITS-1:0];
                CFG_HOMING_EXTRA: r_homing_extra <= i_cfg_data[15:0];
                CFG_STEP_IV:      r_step_iv      <= i_cfg_data[IV_BITS-1:0];
                CFG_EMERG_IV:     r_emerg_iv     <= i_cfg_data[IV_BITS-1:0];
                CFG_INVERT_DIR:   r_invert_dir   <= i_cfg_data[0];
                CFG_ENABLE_PIN:   r_enable_pin   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Divider completes only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the wait step");

    // A capped step count never removes more than the accumulator held
    a_clamp_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY && r_move && r_clamp)
            |-> (r_prod[PROD_BITS-1:ACC_BITS] == '0 && r_prod[ACC_BITS-1:0] <= r_sum))
        else $error("capped steps exceed accumulated time");

    // A refused target only happens on an uncalibrated valve
    a_refuse_uncal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.command_accepted) |-> !o_out.calibrated)
        else $error("target refused on calibrated valve");

    // Save is never requested while homing is still running
    a_save_not_homing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.save_request) |-> !o_out.homing_active)
        else $error("save requested during homing");

endmodule

// ----- hdl/svpc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc_div: radix-2 restoring divider
// Divides the 32-bit accumulator by a nonzero 20-bit interval, one quotient
// bit per cycle; pulses done after the last bit and holds the results.
// ----------------------------------------------------------------------------
module svpc_div
    import svpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_BITS = $clog2(ACC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ACC_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [ACC_BITS-1:0] r_q;
    logic [IV_BITS-1:0]  r_rem;
    logic [IV_BITS-1:0]  r_d;

    logic [IV_BITS:0]    trial;
    logic                fits;
    logic [IV_BITS-1:0]  n_rem;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial = {r_rem, r_q[ACC_BITS-1]};
        fits  = (trial >= {1'b0, r_d});
        n_rem = fits ? IV_BITS'(trial - {1'b0, r_d}) : trial[IV_BITS-1:0];
    end

    // Control: count iterations, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_d   <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[ACC_BITS-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- tb/valve_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_result_checker: prediction and scoreboard for the valve controller
// Watches the config, input and result channels. It keeps its own copy of
// the registers and the valve state, predicts one result per input beat and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module valve_result_checker
    import svpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in                      i_in,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out                     i_out,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_pending,
    output int                       o_fail_count
);

    localparam int PRINT_LIMIT = 40;

    // Register copies
    logic [POS_BITS-1:0]  max_steps_r;
    logic [15:0]          extra_steps_r;
    logic [IV_BITS-1:0]   step_iv_r;
    logic [IV_BITS-1:0]   emerg_iv_r;
    logic                 invert_r;
    logic                 enable_pin_r;

    // Valve state
    logic [POS_BITS-1:0]  valve_pos;
    logic [POS_BITS-1:0]  goal_pos;
    logic [ACC_BITS-1:0]  step_acc;
    logic [STEP_BITS-1:0] homing_left;
    logic                 homing_on;
    logic                 calibrated_r;
    logic                 fast_on;
    logic                 driver_on;
    logic                 pin_dir;

    t_out reports_due[$];
    int   result_idx = 0;
    int   fail_count = 0;
    int   due_count = 0;

    assign o_pending    = due_count;
    assign o_fail_count = fail_count;

    // Print one line per mismatch (up to a limit) and count it
    task automatic report(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $time, result_idx, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            report($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
    endtask

    task automatic compare_result(input t_out got, input t_out want);
        check_field("step_count", 32'(got.step_count), 32'(want.step_count));
        check_field("direction_level", 32'(got.direction_level),
                    32'(want.direction_level));
        check_field("enable_level", 32'(got.enable_level), 32'(want.enable_level));
        check_field("position", 32'(got.position), 32'(want.position));
        check_field("goal_position", 32'(got.goal_position), 32'(want.goal_position));
        check_field("calibrated", 32'(got.calibrated), 32'(want.calibrated));
        check_field("homing_active", 32'(got.homing_active), 32'(want.homing_active));
        check_field("emergency_active", 32'(got.emergency_active),
                    32'(want.emergency_active));
        check_field("save_request", 32'(got.save_request), 32'(want.save_request));
        check_field("command_accepted", 32'(got.command_accepted),
                    32'(want.command_accepted));
    endtask

    // Restore register defaults and clear the valve state
    task automatic reset_model();
        max_steps_r   = RST_MAX_STEPS;
        extra_steps_r = RST_HOMING_XTRA;
        step_iv_r     = RST_STEP_IV;
        emerg_iv_r    = RST_EMERG_IV;
        invert_r      = 1'b0;
        enable_pin_r  = 1'b1;
        valve_pos     = '0;
        goal_pos      = '0;
        step_acc      = '0;
        homing_left   = '0;
        homing_on     = 1'b0;
        calibrated_r  = 1'b0;
        fast_on       = 1'b0;
        driver_on     = 1'b0;
        pin_dir       = 1'b0;
        reports_due.delete();
    endtask

    task automatic load_register(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_MAX_STEPS:    max_steps_r   = data[POS_BITS-1:0];
            CFG_HOMING_EXTRA: extra_steps_r = data[15:0];
            CFG_STEP_IV:      step_iv_r     = data[IV_BITS-1:0];
            CFG_EMERG_IV:     emerg_iv_r    = data[IV_BITS-1:0];
            CFG_INVERT_DIR:   invert_r      = data[0];
            CFG_ENABLE_PIN:   enable_pin_r  = data[0];
            default: ;
        endcase
    endtask

    // Add dt_us to the saturating accumulator and pull out whole intervals,
    // at most limit of them; the remainder stays
    function automatic logic [STEP_BITS-1:0] spend_accumulator(
        input logic [ACC_BITS-1:0]  dt_us,
        input logic [IV_BITS-1:0]   interval,
        input logic [STEP_BITS-1:0] limit
    );
        longint unsigned total;
        longint unsigned per;
        longint unsigned n;
        total = 64'(step_acc) + 64'(dt_us);
        if (total > 64'(ACC_SAT))
            total = 64'(ACC_SAT);
        per = (interval == '0) ? 64'd1 : 64'(interval);
        n = total / per;
        if (n > 64'(limit))
            n = 64'(limit);
        total = total - n * per;
        step_acc = total[ACC_BITS-1:0];
        return n[STEP_BITS-1:0];
    endfunction

    // Apply one input item to the valve state and build its result
    function automatic t_out advance_valve(input t_in it);
        t_out                 r;
        logic [STEP_BITS-1:0] steps;
        logic [ACC_BITS-1:0]  dt_us;
        logic [POS_BITS-1:0]  distance;
        logic [POS_BITS-1:0]  lim;
        logic [POS_BITS-1:0]  tgt;
        logic [IV_BITS-1:0]   iv;
        logic                 opening;
        logic                 save;
        logic                 accepted;
        steps    = '0;
        save     = 1'b0;
        accepted = 1'b1;
        dt_us    = ACC_BITS'(it.elapsed_ms) * ACC_BITS'(US_PER_MS);
        case (it.operation)
            OP_TICK: begin
                if (homing_on) begin
                    steps = spend_accumulator(dt_us, step_iv_r, homing_left);
                    if (steps != '0)
                        pin_dir = invert_r;
                    homing_left = homing_left - steps;
                    if (homing_left == '0) begin
                        valve_pos    = '0;
                        goal_pos     = '0;
                        calibrated_r = 1'b1;
                        homing_on    = 1'b0;
                        save         = 1'b1;
                    end
                end else if (valve_pos != goal_pos) begin
                    opening  = goal_pos > valve_pos;
                    distance = opening ? goal_pos - valve_pos : valve_pos - goal_pos;
                    iv       = fast_on ? emerg_iv_r : step_iv_r;
                    steps    = spend_accumulator(dt_us, iv, STEP_BITS'(distance));
                    if (steps != '0)
                        pin_dir = opening ^ invert_r;
                    valve_pos = opening ? valve_pos + steps[POS_BITS-1:0]
                                        : valve_pos - steps[POS_BITS-1:0];
                    if (valve_pos == goal_pos) begin
                        fast_on = 1'b0;
                        save    = 1'b1;
                    end
                end
            end
            OP_SET_TARGET: begin
                lim = (max_steps_r < POS_MAX) ? max_steps_r : POS_MAX;
                tgt = (it.target_position > lim) ? lim : it.target_position;
                if (!calibrated_r) begin
                    accepted = 1'b0;
                end else begin
                    goal_pos = tgt;
                    if (enable_pin_r)
                        driver_on = 1'b1;
                end
            end
            OP_HOME: begin
                if (enable_pin_r)
                    driver_on = 1'b1;
                homing_left = STEP_BITS'(max_steps_r) + STEP_BITS'(extra_steps_r);
                homing_on   = 1'b1;
                step_acc    = '0;
            end
            default: begin
                goal_pos = '0;
                fast_on  = 1'b1;
                if (enable_pin_r)
                    driver_on = 1'b1;
            end
        endcase
        r.step_count       = steps;
        r.direction_level  = pin_dir;
        r.enable_level     = (enable_pin_r && driver_on) ? 1'b0 : 1'b1;
        r.position         = valve_pos;
        r.goal_position    = goal_pos;
        r.calibrated       = calibrated_r;
        r.homing_active    = homing_on;
        r.emergency_active = fast_on;
        r.save_request     = save;
        r.command_accepted = accepted;
        return r;
    endfunction

    // Register updates first, then retire a result, then predict a new item
    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            reset_model();
            due_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                load_register(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (reports_due.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = reports_due.pop_front();
                    compare_result(i_out, want);
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready)
                reports_due.push_back(advance_valve(i_in));
            due_count <= reports_due.size();
        end
    end

endmodule

// ----- tb/stepper_valve_position_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_valve_position_controller_tb: top of the valve controller bench
// Runs a directed pass over homing, refused and clamped targets, emergency
// close, zero intervals and a missing enable pin, then random phases under
// several register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module stepper_valve_position_controller_tb;
    import svpc_pkg::*;

    // Slowest run: ~1950 beats, each with its divider run, input gap and long
    // stalls, plus one long hold; well under a fifth of this
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 236;
    localparam int HOLD_AFTER    = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_IDX = 3'd7;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in                      i_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out                     o_out;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int accepted_items = 0;
    int cur_max = RST_MAX_STEPS;
    bit sending = 1'b0;
    bit hold_done = 1'b0;

    stepper_valve_position_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    valve_result_checker u_valve_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall patterns of random length, one long hold mid-run
    initial begin : sink
        int mode;
        int span;
        forever begin
            if (!hold_done && sending && accepted_items >= HOLD_AFTER) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in make_item(input t_op op, input int ms, input int pos);
        t_in it;
        it.operation       = op;
        it.elapsed_ms      = ms[MS_BITS-1:0];
        it.target_position = pos[POS_BITS-1:0];
        return it;
    endfunction

    // Mostly ticks and targets up to just past the open limit, some homing and
    // emergency close, plus out-of-range targets and extreme tick lengths
    function automatic t_in random_item();
        t_in it;
        int  roll;
        int  span;
        roll = $urandom_range(0, 99);
        it.elapsed_ms      = MS_BITS'($urandom);
        it.target_position = POS_BITS'($urandom);
        if (roll < 70) begin
            it.operation = OP_TICK;
            case ($urandom_range(0, 5))
                0: it.elapsed_ms = MS_BITS'($urandom_range(0, 20));
                1: it.elapsed_ms = '1;
                default: ;
            endcase
        end else if (roll < 92) begin
            it.operation = OP_SET_TARGET;
            span = cur_max + cur_max / 8 + 2;
            if (span > 65535)
                span = 65535;
            case ($urandom_range(0, 9))
                0: it.target_position = '0;
                1: it.target_position = '1;
                2, 3: ;
                default: it.target_position = POS_BITS'($urandom_range(0, span));
            endcase
        end else if (roll < 96) begin
            it.operation = OP_EMERGENCY;
        end else begin
            it.operation = OP_HOME;
        end
        return it;
    endfunction

    // Hold the beat until the block takes it; valid stays high for the caller
    task automatic send_item(input t_in item);
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        accepted_items++;
    endtask

    // Config beat; valid stays high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write every register, with junk in the unused upper data bits
    task automatic program_valve(input int max_s, input int extra, input int siv,
                                 input int eiv, input bit inv, input bit en);
        write_reg(CFG_MAX_STEPS, {4'($urandom), 16'(max_s)});
        write_reg(CFG_HOMING_EXTRA, {4'($urandom), 16'(extra)});
        write_reg(CFG_STEP_IV, 20'(siv));
        write_reg(CFG_EMERG_IV, 20'(eiv));
        write_reg(CFG_INVERT_DIR, {19'($urandom), inv});
        write_reg(CFG_ENABLE_PIN, {19'($urandom), en});
        write_reg(SPARE_REG_IDX, 20'($urandom));
        i_cfg_valid <= 1'b0;
        cur_max = max_s;
    endtask

    // Wait until every result is back and the block has gone quiet
    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random beats in bursts with random gaps
    task automatic run_random(input int n);
        int left;
        int burst;
        int gap;
        left    = n;
        sending = 1'b1;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                send_item(random_item());
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0 && left > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        sending = 1'b0;
    endtask

    initial begin : stimulus
        int p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: uncalibrated valve, refused target, emergency at zero
        send_item(make_item(OP_TICK, 0, 0));
        send_item(make_item(OP_SET_TARGET, 0, 100));
        send_item(make_item(OP_EMERGENCY, 0, 0));
        send_item(make_item(OP_TICK, 1023, 0));
        i_in_valid <= 1'b0;
        settle();

        // Short stroke, zero emergency interval, inverted direction
        program_valve(10, 5, 1000, 0, 1'b1, 1'b1);
        send_item(make_item(OP_HOME, 0, 0));
        send_item(make_item(OP_SET_TARGET, 0, 65535));
        send_item(make_item(OP_TICK, 3, 0));
        send_item(make_item(OP_TICK, 1023, 0));
        send_item(make_item(OP_SET_TARGET, 0, 65535));
        send_item(make_item(OP_TICK, 0, 0));
        send_item(make_item(OP_TICK, 4, 0));
        send_item(make_item(OP_TICK, 1023, 0));
        send_item(make_item(OP_EMERGENCY, 0, 0));
        send_item(make_item(OP_TICK, 1, 0));
        // target set during homing is dropped when homing ends
        send_item(make_item(OP_HOME, 0, 0));
        send_item(make_item(OP_SET_TARGET, 0, 7));
        send_item(make_item(OP_TICK, 1023, 0));
        i_in_valid <= 1'b0;
        settle();

        // Empty homing stroke, no enable pin
        program_valve(0, 0, 1000000, 1000000, 1'b0, 1'b0);
        send_item(make_item(OP_HOME, 0, 0));
        send_item(make_item(OP_TICK, 0, 0));
        send_item(make_item(OP_SET_TARGET, 0, 5));
        send_item(make_item(OP_EMERGENCY, 0, 0));
        send_item(make_item(OP_TICK, 1023, 0));
        i_in_valid <= 1'b0;
        settle();

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: program_valve(RST_MAX_STEPS, RST_HOMING_XTRA, RST_STEP_IV,
                                 RST_EMERG_IV, 1'b0, 1'b1);
                1: program_valve(65535, 65535, 1, 1000000, 1'b1, 1'b0);
                2: program_valve(0, 0, 1000000, 0, 1'b0, 1'b1);
                default: program_valve($urandom_range(0, 700), $urandom_range(0, 120),
                                       ($urandom_range(0, 1) == 0) ?
                                           $urandom_range(1, 3000) :
                                           $urandom_range(3000, 60000),
                                       $urandom_range(0, 20000),
                                       1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
            endcase
            run_random(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
